// ===== src/nffm_pkg.sv =====
// Shared types and constants for the navigation fault failsafe monitor.
// Holds register indices, event and action codes, reset values and the
// structs passed between the pipeline stages. No dependencies.
package nffm_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 20;

  // Register indices
  localparam logic [CFG_IDX_W-1:0] REG_VARIANCE_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_ACTION    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FAIL_TICKS_LIMIT   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_INTERVAL_MS   = 8'd3;

  // Register reset values
  localparam logic [15:0] THRESHOLD_RST = 16'd205;
  localparam logic [1:0]  ACTION_RST    = 2'd2;
  localparam logic [7:0]  LIMIT_RST     = 8'd10;
  localparam logic [19:0] INTERVAL_RST  = 20'd30000;

  // Failsafe action codes (anything above report means hold)
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;

  // Variance event codes
  localparam logic [1:0] VAR_EV_NONE    = 2'd0;
  localparam logic [1:0] VAR_EV_BAD     = 2'd1;
  localparam logic [1:0] VAR_EV_CLEARED = 2'd2;

  // Failsafe event codes
  localparam logic [1:0] FS_EV_NONE     = 2'd0;
  localparam logic [1:0] FS_EV_RAISED   = 2'd1;
  localparam logic [1:0] FS_EV_RESOLVED = 2'd2;

  // Filter flag bits
  localparam int FF_ABS_OK    = 0;
  localparam int FF_REL_OK    = 1;
  localparam int FF_CONST_POS = 2;

  // Bad tick counter ceiling
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  // Configuration register set
  typedef struct packed {
    logic [15:0] variance_threshold;
    logic [1:0]  failsafe_action;
    logic [7:0]  fail_ticks_limit;
    logic [19:0] warn_interval_ms;
  } cfg_t;

  // Per-tick control bundle handed to the state stage
  typedef struct packed {
    logic        origin_set;
    logic        armed;
    logic        thr_zero;
    logic        over;
    logic        mode_needs_position;
    logic [31:0] now_ms;
  } tick_ctl_t;

  // One result item
  typedef struct packed {
    logic       nav_bad;
    logic       failsafe_on;
    logic [1:0] variance_event;
    logic [1:0] failsafe_event;
    logic       hold_request;
    logic       variance_warning;
    logic       failsafe_text;
  } result_t;

endpackage

// ===== src/navigation_fault_failsafe_monitor_core.sv =====
// Navigation fault failsafe monitor, top level: configuration registers,
// stream handshake and the three-stage pipeline. Uses nffm_pkg, nffm_square,
// nffm_vote and nffm_state.
//
// One tick request is accepted every clock cycle while m_tready keeps the
// result side draining, and each produces exactly one result (the input
// register takes the request, then the squaring register, then the result
// register). The squaring stage squares the three compass variances, and
// the state update completes as each tick enters the result register, so
// back-to-back ticks see each other's effect. Each stage has its own ready,
// so a stalled result register still lets earlier stages fill. Configuration
// writes are always accepted and take effect for ticks accepted at the write
// edge or later; write only while no tick is in flight.
module navigation_fault_failsafe_monitor_core #(
  parameter int VAR_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nffm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nffm_pkg::CFG_DATA_W-1:0] cfg_data,
  // Tick requests
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata, lowest bit up: origin_set, armed, mag_var_x, mag_var_y, mag_var_z,
  // vel_var, pos_var, flow_healthy, inertial_nav, filter_flags[2:0],
  // mode_needs_position, now_ms[31:0], zero fill
  input  logic [((40+5*VAR_WIDTH+7)/8)*8-1:0] s_tdata,
  // Results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata, lowest bit up: nav_bad, failsafe_on, variance_event[1:0],
  // failsafe_event[1:0], hold_request, variance_warning, failsafe_text, zero fill
  output logic [15:0]                   m_tdata
);

  localparam int VW      = VAR_WIDTH;
  localparam int IN_BITS = 40 + 5 * VW;
  localparam int THR_W   = (VW < 16) ? VW : 16;
  localparam int O_MX    = 2;
  localparam int O_MY    = 2 + VW;
  localparam int O_MZ    = 2 + 2 * VW;
  localparam int O_VEL   = 2 + 3 * VW;
  localparam int O_POS   = 2 + 4 * VW;
  localparam int O_FLOW  = 2 + 5 * VW;
  localparam int O_INAV  = 3 + 5 * VW;
  localparam int O_FF    = 4 + 5 * VW;
  localparam int O_MNP   = 7 + 5 * VW;
  localparam int O_NOW   = 8 + 5 * VW;

  nffm_pkg::cfg_t cfg;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.variance_threshold <= nffm_pkg::THRESHOLD_RST;
      cfg.failsafe_action    <= nffm_pkg::ACTION_RST;
      cfg.fail_ticks_limit   <= nffm_pkg::LIMIT_RST;
      cfg.warn_interval_ms   <= nffm_pkg::INTERVAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nffm_pkg::REG_VARIANCE_THRESHOLD: cfg.variance_threshold <= cfg_data[15:0];
        nffm_pkg::REG_FAILSAFE_ACTION:    cfg.failsafe_action    <= cfg_data[1:0];
        nffm_pkg::REG_FAIL_TICKS_LIMIT:   cfg.fail_ticks_limit   <= cfg_data[7:0];
        nffm_pkg::REG_WARN_INTERVAL_MS:   cfg.warn_interval_ms   <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  logic [VW-1:0] threshold;
  assign threshold = VW'(cfg.variance_threshold[THR_W-1:0]);

  // Stage handshake: each stage loads when it is empty or draining
  logic in_valid;
  logic st_valid;
  logic out_valid;
  logic ready_out;
  logic ready_st;
  logic ready_in;
  logic st_load;
  logic state_en;

  assign ready_out = !out_valid || m_tready;
  assign ready_st  = !st_valid || ready_out;
  assign ready_in  = !in_valid || ready_st;
  assign s_tready  = ready_in;
  assign st_load   = in_valid && ready_st;
  assign state_en  = st_valid && ready_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      st_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready_in) begin
        in_valid <= s_tvalid;
      end
      if (ready_st) begin
        st_valid <= in_valid;
      end
      if (ready_out) begin
        out_valid <= st_valid;
      end
    end
  end

  // Input register
  logic [IN_BITS-1:0] in_data;

  always_ff @(posedge clk) begin
    if (ready_in && s_tvalid) begin
      in_data <= s_tdata[IN_BITS-1:0];
    end
  end

  // Squaring stage plus the fields that ride alongside
  logic [2*VW-1:0] sq_x;
  logic [2*VW-1:0] sq_y;
  logic [2*VW-1:0] sq_z;
  logic [2*VW-1:0] t_sq;
  logic [VW-1:0]   st_vel;
  logic [VW-1:0]   st_pos;
  logic            st_flow;
  logic            st_inav;
  logic [2:0]      st_ff;
  logic            st_origin;
  logic            st_armed;
  logic            st_mnp;
  logic [31:0]     st_now;

  nffm_square #(.VAR_WIDTH(VW)) u_square (
    .clk       (clk),
    .en        (st_load),
    .mag_var_x (in_data[O_MX +: VW]),
    .mag_var_y (in_data[O_MY +: VW]),
    .mag_var_z (in_data[O_MZ +: VW]),
    .threshold (threshold),
    .sq_x      (sq_x),
    .sq_y      (sq_y),
    .sq_z      (sq_z),
    .t_sq      (t_sq)
  );

  always_ff @(posedge clk) begin
    if (st_load) begin
      st_origin <= in_data[0];
      st_armed  <= in_data[1];
      st_vel    <= in_data[O_VEL +: VW];
      st_pos    <= in_data[O_POS +: VW];
      st_flow   <= in_data[O_FLOW];
      st_inav   <= in_data[O_INAV];
      st_ff     <= in_data[O_FF +: 3];
      st_mnp    <= in_data[O_MNP];
      st_now    <= in_data[O_NOW +: 32];
    end
  end

  // Vote and state update
  logic                over;
  nffm_pkg::tick_ctl_t ctl;
  nffm_pkg::result_t   res;

  nffm_vote #(.VAR_WIDTH(VW)) u_vote (
    .sq_x         (sq_x),
    .sq_y         (sq_y),
    .sq_z         (sq_z),
    .t_sq         (t_sq),
    .threshold    (threshold),
    .vel_var      (st_vel),
    .pos_var      (st_pos),
    .flow_healthy (st_flow),
    .inertial_nav (st_inav),
    .filter_flags (st_ff),
    .over         (over)
  );

  always_comb begin
    ctl.origin_set          = st_origin;
    ctl.armed               = st_armed;
    ctl.thr_zero            = (threshold == '0);
    ctl.over                = over;
    ctl.mode_needs_position = st_mnp;
    ctl.now_ms              = st_now;
  end

  nffm_state u_state (
    .clk (clk),
    .rst (rst),
    .en  (state_en),
    .ctl (ctl),
    .cfg (cfg),
    .res (res)
  );

  // Result channel
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, res.failsafe_text, res.variance_warning, res.hold_request,
                     res.failsafe_event, res.variance_event, res.failsafe_on, res.nav_bad};

endmodule

// ===== src/nffm_square.sv =====
// Squaring stage: registers the three compass variance squares and the
// squared threshold. Depends on nothing but its ports.
module nffm_square #(
  parameter int VAR_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [VAR_WIDTH-1:0]   mag_var_x,
  input  logic [VAR_WIDTH-1:0]   mag_var_y,
  input  logic [VAR_WIDTH-1:0]   mag_var_z,
  input  logic [VAR_WIDTH-1:0]   threshold,
  output logic [2*VAR_WIDTH-1:0] sq_x,
  output logic [2*VAR_WIDTH-1:0] sq_y,
  output logic [2*VAR_WIDTH-1:0] sq_z,
  output logic [2*VAR_WIDTH-1:0] t_sq
);

  localparam int SQ_W = 2 * VAR_WIDTH;

  // Square the components as the request moves into this stage
  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= SQ_W'(mag_var_x) * SQ_W'(mag_var_x);
      sq_y <= SQ_W'(mag_var_y) * SQ_W'(mag_var_y);
      sq_z <= SQ_W'(mag_var_z) * SQ_W'(mag_var_z);
    end
  end

  // Squared threshold; users change it only while idle (not enforced)
  always_ff @(posedge clk) begin
    t_sq <= SQ_W'(threshold) * SQ_W'(threshold);
  end

endmodule

// ===== src/nffm_vote.sv =====
// Variance vote logic: decides whether one tick is over threshold from the
// registered squares and the raw variances. Uses nffm_pkg flag positions.
module nffm_vote #(
  parameter int VAR_WIDTH = 16
) (
  input  logic [2*VAR_WIDTH-1:0] sq_x,
  input  logic [2*VAR_WIDTH-1:0] sq_y,
  input  logic [2*VAR_WIDTH-1:0] sq_z,
  input  logic [2*VAR_WIDTH-1:0] t_sq,
  input  logic [VAR_WIDTH-1:0]   threshold,
  input  logic [VAR_WIDTH-1:0]   vel_var,
  input  logic [VAR_WIDTH-1:0]   pos_var,
  input  logic                   flow_healthy,
  input  logic                   inertial_nav,
  input  logic [2:0]             filter_flags,
  output logic                   over
);

  localparam int SUM_W = 2 * VAR_WIDTH + 2;

  logic [SUM_W-1:0]   mag_sum;
  logic [VAR_WIDTH:0] t_twice;
  logic               mag_ge;
  logic               vel_ge;
  logic               pos_ge;
  logic               vel_ge_twice;
  logic [2:0]         votes;
  logic               pos_ok;

  // Sum of squares is exact here, so no saturation is needed
  assign mag_sum = SUM_W'(sq_x) + SUM_W'(sq_y) + SUM_W'(sq_z);
  assign mag_ge  = mag_sum >= SUM_W'(t_sq);

  assign t_twice      = {threshold, 1'b0};
  assign vel_ge       = vel_var >= threshold;
  assign pos_ge       = pos_var >= threshold;
  assign vel_ge_twice = {1'b0, vel_var} >= t_twice;

  // Velocity votes twice; second counts two if flow unhealthy, vel >= 2t
  always_comb begin
    votes = 3'(mag_ge) + 3'(vel_ge) + 3'(pos_ge);
    if (!flow_healthy && vel_ge_twice) begin
      votes = votes + 3'd2;
    end else begin
      votes = votes + 3'(vel_ge);
    end
  end

  assign pos_ok = inertial_nav
               && (filter_flags[nffm_pkg::FF_ABS_OK] || filter_flags[nffm_pkg::FF_REL_OK])
               && !filter_flags[nffm_pkg::FF_CONST_POS];

  assign over = (threshold != '0) && ((votes >= 3'd2) || !pos_ok);

endmodule

// ===== src/nffm_state.sv =====
// Failsafe state stage: bad tick counter, variance flag with hysteresis,
// failsafe flag, warning throttle and the result register. Uses nffm_pkg.
module nffm_state (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  nffm_pkg::tick_ctl_t ctl,
  input  nffm_pkg::cfg_t      cfg,
  output nffm_pkg::result_t   res
);

  logic [7:0]  bad_tick_count;
  logic        variance_bad;
  logic        failsafe_active;
  logic [31:0] last_warning_ms;

  logic [7:0]  bad_tick_count_next;
  logic        variance_bad_next;
  logic        failsafe_active_next;
  logic [31:0] last_warning_ms_next;
  nffm_pkg::result_t res_next;

  logic [7:0]  limit;
  logic [7:0]  count_up;
  logic [7:0]  count_down;
  logic [31:0] since_warning;

  assign limit         = (cfg.fail_ticks_limit == '0) ? 8'd1 : cfg.fail_ticks_limit;
  assign count_up      = (bad_tick_count == nffm_pkg::COUNT_MAX) ? bad_tick_count
                                                                 : bad_tick_count + 8'd1;
  assign count_down    = bad_tick_count - 8'd1;
  assign since_warning = ctl.now_ms - last_warning_ms;

  // Work out the next state and the result for this tick
  always_comb begin
    bad_tick_count_next  = bad_tick_count;
    variance_bad_next    = variance_bad;
    failsafe_active_next = failsafe_active;
    last_warning_ms_next = last_warning_ms;
    res_next             = '0;

    if (ctl.origin_set) begin
      if (!ctl.armed || ctl.thr_zero) begin
        // Disarmed or checking off: drop everything
        bad_tick_count_next = '0;
        variance_bad_next   = 1'b0;
        if (failsafe_active) begin
          failsafe_active_next   = 1'b0;
          res_next.failsafe_event = nffm_pkg::FS_EV_RESOLVED;
          res_next.failsafe_text  = 1'b1;
        end
      end else if (ctl.over) begin
        if (!variance_bad) begin
          bad_tick_count_next = count_up;
          if (count_up >= limit) begin
            bad_tick_count_next     = limit;
            variance_bad_next       = 1'b1;
            res_next.variance_event = nffm_pkg::VAR_EV_BAD;
            if (since_warning > 32'(cfg.warn_interval_ms)) begin
              res_next.variance_warning = 1'b1;
              last_warning_ms_next      = ctl.now_ms;
            end
            if (!failsafe_active) begin
              failsafe_active_next    = 1'b1;
              res_next.failsafe_event = nffm_pkg::FS_EV_RAISED;
              if (ctl.mode_needs_position && cfg.failsafe_action != nffm_pkg::ACT_NONE) begin
                res_next.hold_request  = (cfg.failsafe_action != nffm_pkg::ACT_REPORT);
                res_next.failsafe_text = 1'b1;
              end
            end
          end
        end
      end else if (bad_tick_count != '0) begin
        // Decay the count; clear the flag once it reaches zero
        bad_tick_count_next = count_down;
        if (variance_bad && count_down == '0) begin
          variance_bad_next       = 1'b0;
          res_next.variance_event = nffm_pkg::VAR_EV_CLEARED;
          if (failsafe_active) begin
            failsafe_active_next    = 1'b0;
            res_next.failsafe_event = nffm_pkg::FS_EV_RESOLVED;
            res_next.failsafe_text  = 1'b1;
          end
        end
      end
    end

    res_next.nav_bad     = variance_bad_next;
    res_next.failsafe_on = failsafe_active_next;
  end

  // Hold the monitor state
  always_ff @(posedge clk) begin
    if (rst) begin
      bad_tick_count  <= '0;
      variance_bad    <= 1'b0;
      failsafe_active <= 1'b0;
      last_warning_ms <= '0;
    end else if (en) begin
      bad_tick_count  <= bad_tick_count_next;
      variance_bad    <= variance_bad_next;
      failsafe_active <= failsafe_active_next;
      last_warning_ms <= last_warning_ms_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

  // A bad variance flag always comes with an active failsafe
  a_bad_implies_failsafe: assert property (@(posedge clk) disable iff (rst)
    variance_bad |-> failsafe_active)
    else $error("variance flag set without failsafe");

  // The flag never stands with an empty counter
  a_bad_has_count: assert property (@(posedge clk) disable iff (rst)
    variance_bad |-> (bad_tick_count != '0))
    else $error("variance flag set with zero bad tick count");

  // Hold is only requested on the tick that raises the failsafe
  a_hold_on_raise: assert property (@(posedge clk) disable iff (rst)
    (en && res_next.hold_request) |-> (res_next.failsafe_event == nffm_pkg::FS_EV_RAISED))
    else $error("hold requested without a failsafe raise");

  // State moves only with a tick
  a_count_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(bad_tick_count) && $stable(last_warning_ms))
    else $error("state changed without a tick");

endmodule

// ===== dv/tb_navigation_fault_failsafe_monitor_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the navigation fault failsafe monitor core.
// Drives tick requests and register writes, predicts each result from a
// behavioural copy of the monitor state. Depends on nffm_pkg and the core.
module tb_navigation_fault_failsafe_monitor_core;

  localparam int TDATA_W = ((40 + 5 * 16 + 7) / 8) * 8;

  typedef struct {
    logic        origin_set;
    logic        armed;
    logic [15:0] mag_var_x;
    logic [15:0] mag_var_y;
    logic [15:0] mag_var_z;
    logic [15:0] vel_var;
    logic [15:0] pos_var;
    logic        flow_healthy;
    logic        inertial_nav;
    logic [2:0]  filter_flags;
    logic        mode_needs_position;
    logic [31:0] now_ms;
  } tick_t;

  typedef enum logic [1:0] {SEG_BAD, SEG_GOOD, SEG_NOISE} seg_kind_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [nffm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [nffm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [TDATA_W-1:0]              s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [15:0]                     m_tdata;

  // Register copies seen by the predictor
  logic [15:0] thr_q      = nffm_pkg::THRESHOLD_RST;
  logic [1:0]  action_q   = nffm_pkg::ACTION_RST;
  logic [7:0]  limit_q    = nffm_pkg::LIMIT_RST;
  logic [19:0] interval_q = nffm_pkg::INTERVAL_RST;

  // Monitor state copy
  logic [7:0]  bad_ticks = '0;
  logic        var_bad = 1'b0;
  logic        fs_active = 1'b0;
  logic [31:0] last_warn_ms = '0;

  tick_t             pending_ticks[$];
  nffm_pkg::result_t predicted_verdicts[$];
  tick_t             held_tick;
  nffm_pkg::result_t seen, wanted;
  int      ticks_in_flight = 0;
  int      failures = 0;
  bit      calm = 1'b0;
  logic [31:0] clock_ms = '0;

  navigation_fault_failsafe_monitor_core u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the monitor state by one tick and return the result it gives
  function automatic nffm_pkg::result_t advance_monitor(tick_t k);
    nffm_pkg::result_t v;
    logic [63:0] t, sumsq;
    logic [31:0] gap;
    logic [7:0]  lim;
    logic        pos_ok, over;
    int          votes;
    v = '0;
    t = 64'(thr_q);
    if (k.origin_set) begin
      if (!k.armed || t == 0) begin
        bad_ticks = '0;
        var_bad = 1'b0;
        if (fs_active) begin
          fs_active = 1'b0;
          v.failsafe_event = nffm_pkg::FS_EV_RESOLVED;
          v.failsafe_text = 1'b1;
        end
      end else begin
        sumsq = 64'(k.mag_var_x) * 64'(k.mag_var_x) + 64'(k.mag_var_y) * 64'(k.mag_var_y)
              + 64'(k.mag_var_z) * 64'(k.mag_var_z);
        votes = 0;
        if (sumsq >= t * t) votes++;
        if (64'(k.vel_var) >= t) votes++;
        if (64'(k.pos_var) >= t) votes++;
        // velocity votes a second time, doubly when flow is unhealthy and vel >= 2t
        if (!k.flow_healthy && 64'(k.vel_var) >= 2 * t) votes += 2;
        else if (64'(k.vel_var) >= t) votes++;
        pos_ok = k.inertial_nav
                 && (k.filter_flags[nffm_pkg::FF_ABS_OK] || k.filter_flags[nffm_pkg::FF_REL_OK])
                 && !k.filter_flags[nffm_pkg::FF_CONST_POS];
        over = (votes >= 2) || !pos_ok;
        if (over) begin
          if (!var_bad) begin
            lim = (limit_q == 0) ? 8'd1 : limit_q;
            if (bad_ticks != nffm_pkg::COUNT_MAX) bad_ticks++;
            if (bad_ticks >= lim) begin
              bad_ticks = lim;
              var_bad = 1'b1;
              v.variance_event = nffm_pkg::VAR_EV_BAD;
              gap = k.now_ms - last_warn_ms;
              if (gap > 32'(interval_q)) begin
                v.variance_warning = 1'b1;
                last_warn_ms = k.now_ms;
              end
              if (!fs_active) begin
                fs_active = 1'b1;
                v.failsafe_event = nffm_pkg::FS_EV_RAISED;
                if (k.mode_needs_position && action_q != nffm_pkg::ACT_NONE) begin
                  if (action_q != nffm_pkg::ACT_REPORT) v.hold_request = 1'b1;
                  v.failsafe_text = 1'b1;
                end
              end
            end
          end
        end else if (bad_ticks > 0) begin
          // decay; the flag clears only once the count is back at zero
          bad_ticks--;
          if (var_bad && bad_ticks == 0) begin
            var_bad = 1'b0;
            v.variance_event = nffm_pkg::VAR_EV_CLEARED;
            if (fs_active) begin
              fs_active = 1'b0;
              v.failsafe_event = nffm_pkg::FS_EV_RESOLVED;
              v.failsafe_text = 1'b1;
            end
          end
        end
      end
    end
    v.nav_bad = var_bad;
    v.failsafe_on = fs_active;
    return v;
  endfunction

  // Variance value at or over (or under) the current threshold
  function automatic logic [15:0] pick_var(bit high);
    int unsigned t, hi;
    t = thr_q;
    if (high) begin
      hi = (2 * t + 2 > 65535) ? 65535 : 2 * t + 2;
      if ($urandom_range(0, 7) == 0) return 16'(t);
      if ($urandom_range(0, 15) == 0) return 16'hFFFF;
      return 16'($urandom_range(hi, t));
    end
    if (t == 0) return 16'd0;
    if ($urandom_range(0, 7) == 0) return 16'(t - 1);
    return 16'($urandom_range(t - 1, 0));
  endfunction

  task automatic note_failure(input string msg);
    failures++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
    if (got !== want) note_failure($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic push_tick(input tick_t k);
    pending_ticks.push_back(k);
    ticks_in_flight++;
  endtask

  // Build one tick of the given kind around the current threshold
  task automatic queue_tick(input seg_kind_t kind);
    tick_t k;
    int    why, r;
    logic [15:0] half;
    half = thr_q >> 1;
    why = $urandom_range(0, 3);
    k.origin_set = ($urandom_range(0, 19) != 0);
    k.armed = ($urandom_range(0, 29) != 0);
    k.mode_needs_position = ($urandom_range(0, 3) != 0);
    k.flow_healthy = 1'($urandom_range(0, 1));
    k.inertial_nav = 1'b1;
    k.filter_flags = {1'b0, 2'($urandom_range(1, 3))};
    k.mag_var_x = 16'($urandom_range(half, 0));
    k.mag_var_y = 16'($urandom_range(half, 0));
    k.mag_var_z = 16'($urandom_range(half, 0));
    k.vel_var = pick_var(1'b0);
    k.pos_var = pick_var(1'b0);
    case (kind)
      SEG_BAD: begin
        case (why)
          0: begin
            case ($urandom_range(0, 2))
              0: k.inertial_nav = 1'b0;
              1: k.filter_flags = 3'($urandom_range(0, 7)) | 3'b100;
              default: k.filter_flags = 3'b000;
            endcase
          end
          1: k.vel_var = pick_var(1'b1);
          2: begin
            k.mag_var_y = pick_var(1'b1);
            k.pos_var = pick_var(1'b1);
          end
          default: begin
            k.flow_healthy = 1'b0;
            k.vel_var = pick_var(1'b1);
          end
        endcase
      end
      SEG_GOOD: begin
        // a single vote still leaves the tick good
        if (why == 0) k.pos_var = pick_var(1'b1);
        else if (why == 1) k.mag_var_z = pick_var(1'b1);
      end
      default: begin
        k.origin_set = 1'($urandom);
        k.armed = 1'($urandom);
        k.mag_var_x = 16'($urandom);
        k.mag_var_y = 16'($urandom);
        k.mag_var_z = 16'($urandom);
        k.vel_var = 16'($urandom);
        k.pos_var = 16'($urandom);
        k.flow_healthy = 1'($urandom);
        k.inertial_nav = 1'($urandom);
        k.filter_flags = 3'($urandom);
        k.mode_needs_position = 1'($urandom);
      end
    endcase
    // move time on, now and then jumping anywhere
    r = $urandom_range(0, 99);
    if (r < 70) clock_ms = clock_ms + $urandom_range(0, 2000);
    else if (r < 95) clock_ms = clock_ms + $urandom_range(0, 50000);
    else clock_ms = $urandom;
    k.now_ms = clock_ms;
    push_tick(k);
  endtask

  task automatic write_reg(input logic [nffm_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[nffm_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      nffm_pkg::REG_VARIANCE_THRESHOLD: thr_q = value[15:0];
      nffm_pkg::REG_FAILSAFE_ACTION:    action_q = value[1:0];
      nffm_pkg::REG_FAIL_TICKS_LIMIT:   limit_q = value[7:0];
      nffm_pkg::REG_WARN_INTERVAL_MS:   interval_q = value[19:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (ticks_in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reprogram the block, then run bad, good and noise stretches of random length
  task automatic run_phase(input int unsigned thr, input int unsigned act,
                           input int unsigned lim, input int unsigned ival,
                           input int n, input bit quiet);
    int made, roll, len, eff;
    seg_kind_t kind;
    wait_drained();
    write_reg(nffm_pkg::REG_VARIANCE_THRESHOLD, thr);
    write_reg(nffm_pkg::REG_FAILSAFE_ACTION, act);
    write_reg(nffm_pkg::REG_FAIL_TICKS_LIMIT, lim);
    write_reg(nffm_pkg::REG_WARN_INTERVAL_MS, ival);
    repeat (3) @(posedge clk);
    calm = quiet;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(0, 9);
      eff = (limit_q == 0) ? 1 : limit_q;
      len = $urandom_range(0, 1) ? eff + $urandom_range(0, 3) : $urandom_range(1, eff);
      kind = (roll < 5) ? SEG_BAD : (roll < 9) ? SEG_GOOD : SEG_NOISE;
      if (kind == SEG_NOISE) len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        queue_tick(kind);
        made++;
      end
    end
  endtask

  // Present pending ticks; predict each one as its request is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) predicted_verdicts.push_back(advance_monitor(held_tick));
      if (!s_tvalid || s_tready) begin
        if (pending_ticks.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
          held_tick = pending_ticks.pop_front();
          s_tdata <= {held_tick.now_ms, held_tick.mode_needs_position, held_tick.filter_flags,
                      held_tick.inertial_nav, held_tick.flow_healthy, held_tick.pos_var,
                      held_tick.vel_var, held_tick.mag_var_z, held_tick.mag_var_y,
                      held_tick.mag_var_x, held_tick.armed, held_tick.origin_set};
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Take results and compare each against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (predicted_verdicts.size() == 0) begin
          note_failure("result with no tick waiting");
        end else begin
          wanted = predicted_verdicts.pop_front();
          seen.nav_bad = m_tdata[0];
          seen.failsafe_on = m_tdata[1];
          seen.variance_event = m_tdata[3:2];
          seen.failsafe_event = m_tdata[5:4];
          seen.hold_request = m_tdata[6];
          seen.variance_warning = m_tdata[7];
          seen.failsafe_text = m_tdata[8];
          check_field("nav_bad", seen.nav_bad, wanted.nav_bad);
          check_field("failsafe_on", seen.failsafe_on, wanted.failsafe_on);
          check_field("variance_event", seen.variance_event, wanted.variance_event);
          check_field("failsafe_event", seen.failsafe_event, wanted.failsafe_event);
          check_field("hold_request", seen.hold_request, wanted.hold_request);
          check_field("variance_warning", seen.variance_warning, wanted.variance_warning);
          check_field("failsafe_text", seen.failsafe_text, wanted.failsafe_text);
          ticks_in_flight--;
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed ticks at the reset register values
    push_tick('{1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                1'b1, 1'b1, 3'd7, 1'b1, 32'hFFFF_FFFF});  // no origin
    push_tick('{1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                1'b0, 1'b0, 3'd0, 1'b0, 32'd0});          // disarmed
    push_tick('{1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                1'b1, 1'b1, 3'd7, 1'b1, 32'hFFFF_FFFF});  // everything over
    push_tick('{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                1'b0, 1'b0, 3'd0, 1'b0, 32'd100});        // no position estimate
    push_tick('{1'b1, 1'b1, 16'd10, 16'd10, 16'd10, 16'd10, 16'd10,
                1'b1, 1'b1, 3'd1, 1'b1, 32'd200});        // good tick
    push_tick('{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd410, 16'd0,
                1'b0, 1'b1, 3'd2, 1'b1, 32'd300});        // unhealthy flow, vel at 2t
    push_tick('{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd205, 16'd0,
                1'b1, 1'b1, 3'd3, 1'b1, 32'd400});        // vel exactly at t
    push_tick('{1'b1, 1'b1, 16'd205, 16'd0, 16'd0, 16'd0, 16'd205,
                1'b1, 1'b1, 3'd1, 1'b1, 32'd500});        // magnitude and position at t
    push_tick('{1'b1, 1'b1, 16'd204, 16'd0, 16'd0, 16'd0, 16'd205,
                1'b1, 1'b1, 3'd2, 1'b1, 32'd600});        // one vote only
    push_tick('{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                1'b1, 1'b1, 3'd7, 1'b0, 32'd700});        // constant position mode
    // Push the count up to the limit: flag, warn and raise with hold
    for (int i = 0; i < 6; i++)
      push_tick('{1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                  1'b1, 1'b1, 3'd0, 1'b1, 32'd40000 + i});
    push_tick('{1'b1, 1'b1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0,
                1'b0, 1'b0, 3'd4, 1'b1, 32'd40010});      // already bad
    push_tick('{1'b0, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                1'b0, 1'b0, 3'd0, 1'b0, 32'd40020});      // no origin keeps state
    push_tick('{1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                1'b0, 1'b0, 3'd0, 1'b1, 32'd40030});      // disarm resolves
    clock_ms = 32'd40030;

    // Random phases across register settings
    run_phase(205, 2, 3, 30000, 260, 1'b0);
    run_phase(1, 1, 1, 0, 200, 1'b1);
    run_phase(65535, 0, 5, 600000, 200, 1'b0);
    run_phase(0, 2, 4, 1000, 40, 1'b0);
    run_phase(4000, 3, 0, 5000, 250, 1'b0);
    run_phase(300, 2, 255, 20000, 600, 1'b0);
    run_phase($urandom_range(1, 65535), $urandom_range(0, 3), $urandom_range(1, 20),
              $urandom_range(0, 600000), 260, 1'b0);
    wait_drained();
    repeat (6) @(posedge clk);

    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Give up if the block stops answering
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
